/* rtl/core/ace_pkg.sv */
// Shared types, codes and constants of the accumulator execute block.
package ace_pkg;

	localparam int MEM_WORDS_DEF = 1024;
	localparam int VSTACK_DEPTH_DEF = 64;
	localparam int RSTACK_DEPTH_DEF = 32;

	typedef enum logic [3:0] {
		OP_HALT = 4'd0, OP_READNUM = 4'd1, OP_READKEY = 4'd2, OP_LOAD = 4'd3,
		OP_STORE = 4'd4, OP_ADD = 4'd5, OP_SUB = 4'd6, OP_MOD = 4'd7,
		OP_JNZ = 4'd8, OP_JEZ = 4'd9, OP_CALL = 4'd10, OP_RET = 4'd11,
		OP_PUSH = 4'd12, OP_POP = 4'd13, OP_OUT = 4'd14, OP_OUTCHAR = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0, SRC_ACC = 2'd1, SRC_MEM = 2'd2, SRC_CONST = 2'd3
	} src_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_BAD_RET = 3'd1, ST_POP_EMPTY = 3'd2,
		ST_BAD_ADDR = 3'd3, ST_MOD_ZERO = 3'd4, ST_FULL = 3'd5
	} status_t;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] flag;
		logic [15:0] operand;
		logic [15:0] in_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic halted;
		logic out_valid;
		logic [15:0] out_value;
		logic out_is_char;
		logic [2:0] status;
	} out_item_t;

	// divider control between sequencer and modulo unit
	typedef struct packed {
		logic start;
		logic [15:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

endpackage

/* rtl/core/ace_ram.sv */
// Generic single-port synchronous RAM with registered read.
module ace_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* rtl/core/ace_mod.sv */
// Restoring remainder unit, one quotient bit per cycle.
module ace_mod (
	input  logic clk,
	input  logic arst_n,
	input  ace_pkg::div_req_t req,
	output logic busy,
	output logic [15:0] rem
);
	logic [15:0] rem_q, dvd_q, dvs_q;
	logic [4:0] cnt_q;
	logic [16:0] trial;

	assign trial = {rem_q, dvd_q[15]} - {1'b0, dvs_q};
	assign busy = (cnt_q != 5'd0);
	assign rem = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (req.start) begin
			cnt_q <= 5'd16;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	// shift one dividend bit in and subtract when it fits
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= 16'd0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy) begin
			dvd_q <= {dvd_q[14:0], 1'b0};
			rem_q <= trial[16] ? {rem_q[14:0], dvd_q[15]} : trial[15:0];
		end
	end
endmodule

/* rtl/core/accumulator_cpu_execute.sv */
// Top level of the accumulator machine execute block.
//  channel | dir | payload       | handshake
//  in      | in  | in_item_t     | in_valid / in_stall
//  res     | out | out_item_t    | res_valid / res_stall
// An instruction passes accept, memory/stack read and write back before the next
// one is accepted; its result is valid the cycle after write back.
// mod with a nonzero divisor also waits in the bit-serial remainder unit.
// After reset a clearing pass writes zero to every data memory word,
// with no instruction accepted meanwhile.
// A stalled result holds the output register; the next instruction runs up to
// write back and waits there until the result is taken.
module accumulator_cpu_execute #(
	parameter int MEM_WORDS = ace_pkg::MEM_WORDS_DEF,
	parameter int VALUE_STACK_DEPTH = ace_pkg::VSTACK_DEPTH_DEF,
	parameter int RETURN_STACK_DEPTH = ace_pkg::RSTACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  ace_pkg::in_item_t in_data,
	output logic res_valid,
	input  logic res_stall,
	output ace_pkg::out_item_t res_data
);
	localparam int MAW = $clog2(MEM_WORDS);
	localparam int VAW = $clog2(VALUE_STACK_DEPTH);
	localparam int RAW = $clog2(RETURN_STACK_DEPTH);
	localparam int VCW = $clog2(VALUE_STACK_DEPTH + 1);
	localparam int RCW = $clog2(RETURN_STACK_DEPTH + 1);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001, S_IDLE = 5'b00010, S_READ = 5'b00100,
		S_DIV = 5'b01000, S_WB = 5'b10000
	} state_t;

	state_t state_q;
	ace_pkg::in_item_t ins_q;
	logic [15:0] acc_q, pc_q;
	logic halt_q;
	logic [VCW-1:0] vcnt_q;
	logic [RCW-1:0] rcnt_q;
	logic [MAW:0] clr_q;
	logic div_wait_q;

	// memory ports
	logic m_we, v_we, r_we;
	logic [MAW-1:0] m_addr;
	logic [VAW-1:0] v_addr;
	logic [RAW-1:0] r_addr;
	logic [15:0] m_wdata, m_rdata, v_wdata, v_rdata, r_wdata, r_rdata;

	ace_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_dmem (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata));
	ace_ram #(.WIDTH(16), .DEPTH(VALUE_STACK_DEPTH)) u_vstk (
		.clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata));
	ace_ram #(.WIDTH(16), .DEPTH(RETURN_STACK_DEPTH)) u_rstk (
		.clk(clk), .we(r_we), .addr(r_addr), .wdata(r_wdata), .rdata(r_rdata));

	ace_pkg::div_req_t dreq;
	logic dbusy;
	logic [15:0] drem;
	ace_mod u_mod (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .rem(drem));

	// write back commits once the output register is free
	logic wb_fire;
	assign wb_fire = (state_q == S_WB) && !(res_valid && res_stall);

	// decode of the held instruction
	logic addr_ok, v_empty, v_full, r_empty, r_full;
	logic [15:0] pc_inc, src_val;
	logic src_none;
	assign addr_ok = ({16'd0, ins_q.operand} < 32'(MEM_WORDS));
	assign v_empty = (vcnt_q == '0);
	assign v_full = (vcnt_q == VCW'(VALUE_STACK_DEPTH));
	assign r_empty = (rcnt_q == '0);
	assign r_full = (rcnt_q == RCW'(RETURN_STACK_DEPTH));
	assign pc_inc = pc_q + 16'd1;
	assign src_none = (ins_q.flag == ace_pkg::SRC_NONE);

	always_comb begin
		unique case (ace_pkg::src_t'(ins_q.flag))
			ace_pkg::SRC_ACC: src_val = acc_q;
			ace_pkg::SRC_MEM: src_val = m_rdata;
			ace_pkg::SRC_CONST: src_val = ins_q.operand;
			default: src_val = 16'd0;
		endcase
	end

	logic src_bad;
	assign src_bad = (ins_q.flag == ace_pkg::SRC_MEM) && !addr_ok;

	// memory addressing: clear pass, then operand / stack tops
	always_comb begin
		m_we = 1'b0;
		m_addr = ins_q.operand[MAW-1:0];
		m_wdata = 16'd0;
		v_we = 1'b0;
		v_addr = VAW'(vcnt_q - VCW'(1));
		v_wdata = src_val;
		r_we = 1'b0;
		r_addr = RAW'(rcnt_q - RCW'(1));
		r_wdata = pc_inc;
		dreq = '0;
		if (state_q == S_CLEAR) begin
			m_we = 1'b1;
			m_addr = clr_q[MAW-1:0];
		end else if (state_q == S_IDLE) begin
			m_addr = in_data.operand[MAW-1:0];
		end else if (wb_fire && !halt_q) begin
			unique case (ace_pkg::op_t'(ins_q.op))
				ace_pkg::OP_READNUM, ace_pkg::OP_READKEY: begin
					m_we = addr_ok;
					m_wdata = ins_q.in_value;
				end
				ace_pkg::OP_STORE: begin
					m_we = addr_ok;
					m_wdata = acc_q;
				end
				ace_pkg::OP_POP: begin
					m_we = addr_ok && !v_empty;
					m_wdata = v_rdata;
				end
				ace_pkg::OP_PUSH: begin
					v_we = !src_none && !src_bad && !v_full;
					v_addr = VAW'(vcnt_q);
				end
				ace_pkg::OP_CALL: begin
					r_we = !r_full;
					r_addr = RAW'(rcnt_q);
				end
				default: ;
			endcase
		end
		if (state_q == S_READ) begin
			dreq.start = (ins_q.op == ace_pkg::OP_MOD) && !halt_q && !src_none &&
				!src_bad && (src_val != 16'd0);
			dreq.dividend = acc_q;
			dreq.divisor = src_val;
		end
	end

	// result of the held instruction
	ace_pkg::out_item_t res_n;
	logic [15:0] acc_n;
	always_comb begin
		res_n = '0;
		acc_n = acc_q;
		res_n.next_pc = pc_inc;
		res_n.halted = halt_q;
		if (halt_q) begin
			res_n.next_pc = pc_q;
		end else begin
			unique case (ace_pkg::op_t'(ins_q.op))
				ace_pkg::OP_HALT: res_n.halted = 1'b1;
				ace_pkg::OP_READNUM, ace_pkg::OP_READKEY, ace_pkg::OP_STORE:
					if (!addr_ok) res_n.status = ace_pkg::ST_BAD_ADDR;
				ace_pkg::OP_LOAD:
					if (src_bad) res_n.status = ace_pkg::ST_BAD_ADDR;
					else if (!src_none)
						acc_n = (ins_q.flag == ace_pkg::SRC_ACC) ? 16'd0 : src_val;
				ace_pkg::OP_ADD:
					if (src_bad) res_n.status = ace_pkg::ST_BAD_ADDR;
					else if (!src_none) acc_n = acc_q + src_val;
				ace_pkg::OP_SUB:
					if (src_bad) res_n.status = ace_pkg::ST_BAD_ADDR;
					else if (!src_none) acc_n = acc_q - src_val;
				ace_pkg::OP_MOD:
					if (src_bad) res_n.status = ace_pkg::ST_BAD_ADDR;
					else if (!src_none) begin
						if (src_val == 16'd0) res_n.status = ace_pkg::ST_MOD_ZERO;
						else acc_n = drem;
					end
				ace_pkg::OP_JNZ: if (acc_q != 16'd0) res_n.next_pc = ins_q.operand;
				ace_pkg::OP_JEZ: if (acc_q == 16'd0) res_n.next_pc = ins_q.operand;
				ace_pkg::OP_CALL:
					if (r_full) res_n.status = ace_pkg::ST_FULL;
					else res_n.next_pc = ins_q.operand;
				ace_pkg::OP_RET:
					if (r_empty) res_n.status = ace_pkg::ST_BAD_RET;
					else res_n.next_pc = r_rdata;
				ace_pkg::OP_PUSH:
					if (src_bad) res_n.status = ace_pkg::ST_BAD_ADDR;
					else if (!src_none && v_full) res_n.status = ace_pkg::ST_FULL;
				ace_pkg::OP_POP:
					if (v_empty) res_n.status = ace_pkg::ST_POP_EMPTY;
					else if (!addr_ok) res_n.status = ace_pkg::ST_BAD_ADDR;
				ace_pkg::OP_OUT, ace_pkg::OP_OUTCHAR:
					if (src_bad) res_n.status = ace_pkg::ST_BAD_ADDR;
					else if (!src_none) begin
						res_n.out_valid = 1'b1;
						res_n.out_is_char = (ins_q.op == ace_pkg::OP_OUTCHAR);
						res_n.out_value = res_n.out_is_char ? {8'd0, src_val[7:0]}
							: src_val;
					end
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !in_stall) begin
			ins_q <= in_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			acc_q <= 16'd0;
			pc_q <= 16'd0;
			halt_q <= 1'b0;
			vcnt_q <= '0;
			rcnt_q <= '0;
			res_valid <= 1'b0;
			div_wait_q <= 1'b0;
		end else begin
			if (wb_fire) res_valid <= 1'b1;
			else if (!res_stall) res_valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (MAW+1)'(MEM_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid && !in_stall) state_q <= S_READ;
				S_READ: begin
					div_wait_q <= dreq.start;
					state_q <= dreq.start ? S_DIV : S_WB;
				end
				S_DIV: if (!dbusy && !div_wait_q) state_q <= S_WB;
					else div_wait_q <= 1'b0;
				S_WB: if (wb_fire) begin
					state_q <= S_IDLE;
					pc_q <= res_n.next_pc;
					halt_q <= res_n.halted;
					acc_q <= acc_n;
					if (!halt_q && res_n.status == ace_pkg::ST_OK) begin
						if (ins_q.op == ace_pkg::OP_CALL) rcnt_q <= rcnt_q + 1'b1;
						if (ins_q.op == ace_pkg::OP_RET) rcnt_q <= rcnt_q - 1'b1;
						if (ins_q.op == ace_pkg::OP_PUSH && !src_none)
							vcnt_q <= vcnt_q + 1'b1;
						if (ins_q.op == ace_pkg::OP_POP) vcnt_q <= vcnt_q - 1'b1;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wb_fire) res_data <= res_n;
	end
endmodule

/* rtl/core/ace_checker.sv */
// Port-level checker for the execute block, bound to the top level.
module ace_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic res_valid,
	input logic res_stall,
	input ace_pkg::out_item_t res_data
);
	// an accepted instruction occupies the block for the next cycle
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("accepted back to back");
	// result stays while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed");
	// halted is sticky
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.halted ##1 res_valid && !$past(res_valid && res_stall)
		|-> res_data.halted) else $error("halt lost");
	// no emission without ok status
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.out_valid |-> res_data.status == ace_pkg::ST_OK)
		else $error("emission with error");
endmodule

bind accumulator_cpu_execute ace_checker u_ace_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data));

/* dv/tb.sv */
// Testbench for the accumulator machine execute block: random and directed instructions.
`timescale 1ns / 1ps
module tb;
	import ace_pkg::*;

	localparam int MEMW = MEM_WORDS_DEF;
	localparam int VDEPTH = VSTACK_DEPTH_DEF;
	localparam int RDEPTH = RSTACK_DEPTH_DEF;
	localparam int MAW_TB = $clog2(MEMW);
	localparam int VAW_TB = $clog2(VDEPTH);
	localparam int RAW_TB = $clog2(RDEPTH);
	localparam int WATCHDOG_LIMIT = 20000;

	// Execution-state predictor and queue of pending results
	class exec_scoreboard;
		logic [15:0] acc, pc;
		logic halt_q;
		logic [15:0] dmem [MEMW];
		logic [15:0] vstk [VDEPTH];
		logic [15:0] rstk [RDEPTH];
		int vcnt, rcnt;
		out_item_t pending[$];
		int errors;

		function void clear();
			acc = 0; pc = 0; halt_q = 0; vcnt = 0; rcnt = 0; errors = 0;
			foreach (dmem[i]) dmem[i] = 0;
			pending.delete();
		endfunction

		function status_t read_src(src_t s, logic [15:0] opnd, output logic [15:0] v);
			v = 0;
			case (s)
				SRC_ACC: v = acc;
				SRC_MEM: begin
					if (opnd >= MEMW) return ST_BAD_ADDR;
					v = dmem[opnd[MAW_TB-1:0]];
				end
				SRC_CONST: v = opnd;
				default: v = 0;
			endcase
			return ST_OK;
		endfunction

		// Work out the effect of one accepted instruction
		function void note_instr(in_item_t it);
			out_item_t r;
			status_t st;
			logic [15:0] v;
			op_t op;
			src_t s;
			st = ST_OK;
			op = op_t'(it.op);
			s = src_t'(it.flag);
			r = '0;
			if (!halt_q) begin
				pc = pc + 16'd1;
				case (op)
					OP_HALT: halt_q = 1;
					OP_READNUM, OP_READKEY, OP_STORE: begin
						if (it.operand >= MEMW) st = ST_BAD_ADDR;
						else dmem[it.operand[MAW_TB-1:0]] = (op == OP_STORE) ? acc
							: it.in_value;
					end
					OP_LOAD, OP_ADD, OP_SUB, OP_MOD, OP_PUSH, OP_OUT, OP_OUTCHAR: begin
						st = read_src(s, it.operand, v);
						if (st == ST_OK && s != SRC_NONE) begin
							case (op)
								OP_LOAD: acc = (s == SRC_ACC) ? 16'd0 : v;
								OP_ADD: acc = acc + v;
								OP_SUB: acc = acc - v;
								OP_MOD: begin
									if (v == 0) st = ST_MOD_ZERO;
									else acc = acc % v;
								end
								OP_PUSH: begin
									if (vcnt >= VDEPTH) st = ST_FULL;
									else begin
										vstk[vcnt[VAW_TB-1:0]] = v;
										vcnt++;
									end
								end
								default: begin
									r.out_valid = 1;
									r.out_is_char = (op == OP_OUTCHAR);
									r.out_value = (op == OP_OUTCHAR) ? {8'd0, v[7:0]} : v;
								end
							endcase
						end
					end
					OP_JNZ: if (acc != 0) pc = it.operand;
					OP_JEZ: if (acc == 0) pc = it.operand;
					OP_CALL: begin
						if (rcnt >= RDEPTH) st = ST_FULL;
						else begin
							rstk[rcnt[RAW_TB-1:0]] = pc;
							rcnt++;
							pc = it.operand;
						end
					end
					OP_RET: begin
						if (rcnt == 0) st = ST_BAD_RET;
						else begin
							rcnt--;
							pc = rstk[rcnt[RAW_TB-1:0]];
						end
					end
					default: begin // pop
						if (vcnt == 0) st = ST_POP_EMPTY;
						else if (it.operand >= MEMW) st = ST_BAD_ADDR;
						else begin
							vcnt--;
							dmem[it.operand[MAW_TB-1:0]] = vstk[vcnt[VAW_TB-1:0]];
						end
					end
				endcase
			end
			r.next_pc = pc;
			r.halted = halt_q;
			r.status = st;
			pending.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result %p", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.next_pc !== e.next_pc)
				$display("%0t next_pc exp %h got %h", $time, e.next_pc, got.next_pc);
			if (got.halted !== e.halted)
				$display("%0t halted exp %b got %b", $time, e.halted, got.halted);
			if (got.out_valid !== e.out_valid)
				$display("%0t out_valid exp %b got %b", $time, e.out_valid, got.out_valid);
			if (got.out_value !== e.out_value)
				$display("%0t out_value exp %h got %h", $time, e.out_value, got.out_value);
			if (got.out_is_char !== e.out_is_char)
				$display("%0t out_is_char exp %b got %b", $time, e.out_is_char, got.out_is_char);
			if (got.status !== e.status)
				$display("%0t status exp %0d got %0d", $time, e.status, got.status);
			if (got !== e) errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_data = '0;
	logic res_valid;
	logic res_stall = 0;
	out_item_t res_data;

	exec_scoreboard sb = new();
	int send_idle = 0, recv_idle = 0;
	int quiet_cycles = 0;

	accumulator_cpu_execute dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .res_valid(res_valid), .res_stall(res_stall),
		.res_data(res_data)
	);

	always #10 clk = ~clk;

	// Result side: random stall, check every transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) sb.check_result(res_data);
			res_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (res_valid && !res_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Drive one instruction and wait for its transaction; valid stays up for the next one
	task automatic send_instr(op_t op, src_t s, logic [15:0] opnd, logic [15:0] iv);
		in_item_t it;
		it.op = op;
		it.flag = s;
		it.operand = opnd;
		it.in_value = iv;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_instr(it);
	endtask

	function automatic logic [15:0] pick_addr();
		case ($urandom_range(9))
			0: return 16'($urandom_range(65535, MEMW));
			1: return 16'(MEMW - 1);
			default: return 16'($urandom_range(15));
		endcase
	endfunction

	task automatic random_instr();
		op_t op;
		src_t s;
		logic [15:0] opnd;
		int k;
		k = $urandom_range(99);
		// halt is left to the directed part since it freezes the block until reset
		op = op_t'($urandom_range(15, 1));
		s = src_t'($urandom_range(3));
		if (op == OP_JNZ || op == OP_JEZ || op == OP_CALL || (s == SRC_CONST && k < 50))
			opnd = 16'($urandom());
		else opnd = pick_addr();
		send_instr(op, s, opnd, 16'($urandom()));
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		sb.clear();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, every op and the error cases
		send_instr(OP_RET, SRC_NONE, 16'd0, 16'd0);
		send_instr(OP_POP, SRC_NONE, 16'hFFFF, 16'd0);
		send_instr(OP_READNUM, SRC_NONE, 16'd0, 16'hFFFF);
		send_instr(OP_READKEY, SRC_NONE, 16'(MEMW - 1), 16'h00A5);
		send_instr(OP_READNUM, SRC_NONE, 16'(MEMW), 16'h1234);
		send_instr(OP_LOAD, SRC_MEM, 16'd0, 16'd0);
		send_instr(OP_ADD, SRC_CONST, 16'hFFFF, 16'd0);
		send_instr(OP_SUB, SRC_CONST, 16'hFFFF, 16'd0);
		send_instr(OP_MOD, SRC_CONST, 16'd0, 16'd0);
		send_instr(OP_MOD, SRC_MEM, 16'(MEMW - 1), 16'd0);
		send_instr(OP_LOAD, SRC_ACC, 16'd0, 16'd0);
		send_instr(OP_ADD, SRC_NONE, 16'd5, 16'd0);
		send_instr(OP_JEZ, SRC_NONE, 16'hFFFF, 16'd0);
		send_instr(OP_JNZ, SRC_NONE, 16'h0010, 16'd0);
		send_instr(OP_CALL, SRC_NONE, 16'h0100, 16'd0);
		send_instr(OP_RET, SRC_NONE, 16'd0, 16'd0);
		send_instr(OP_PUSH, SRC_CONST, 16'h8001, 16'd0);
		send_instr(OP_POP, SRC_NONE, 16'(MEMW), 16'd0);
		send_instr(OP_POP, SRC_NONE, 16'd3, 16'd0);
		send_instr(OP_STORE, SRC_NONE, 16'hFFFF, 16'd0);
		send_instr(OP_OUT, SRC_MEM, 16'd3, 16'd0);
		send_instr(OP_OUTCHAR, SRC_CONST, 16'hABCD, 16'd0);
		send_instr(OP_OUT, SRC_MEM, 16'hFFFF, 16'd0);

		// Fill both stacks past their depth, then empty them past zero
		repeat (VDEPTH + 1) send_instr(OP_PUSH, SRC_CONST, 16'($urandom()), 16'd0);
		repeat (RDEPTH + 1) send_instr(OP_CALL, SRC_NONE, 16'($urandom()), 16'd0);
		repeat (RDEPTH + 1) send_instr(OP_RET, SRC_NONE, 16'd0, 16'd0);
		repeat (VDEPTH + 1) send_instr(OP_POP, SRC_NONE, 16'($urandom_range(15)), 16'd0);

		// Random phases with different idling
		send_idle = 28; recv_idle = 86;
		repeat (140) random_instr();
		send_idle = 86; recv_idle = 28;
		repeat (140) random_instr();
		send_idle = 0; recv_idle = 0;
		repeat (140) random_instr();
		// Halt then confirm frozen behavior
		send_instr(OP_HALT, SRC_NONE, 16'd0, 16'd0);
		repeat (8) random_instr();

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
